FILE: src/assert_macros.svh
// assertion macros for the rtl of the sequence engine
// each use expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ISRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next clock edge outside reset
`define ISRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/isre_pkg.sv
// shared types and codes for the indexed sequence range engine
// no dependencies
`default_nettype none
package isre_pkg;

  localparam int CAPACITY_DEF = 256;

  // request codes
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_ADD    = 3'd2;
  localparam logic [2:0] REQ_QUERY  = 3'd3;
  localparam logic [2:0] REQ_LBOUND = 3'd4;

  // cell operation codes
  localparam logic [2:0] CELL_HOLD = 3'd0;
  localparam logic [2:0] CELL_INS  = 3'd1;
  localparam logic [2:0] CELL_REM  = 3'd2;
  localparam logic [2:0] CELL_ADD  = 3'd3;
  localparam logic [2:0] CELL_ROT  = 3'd4;

  // command broadcast to every cell
  typedef struct packed {
    logic [2:0]  op;
    logic [8:0]  pos;
    logic [7:0]  last;
    logic [63:0] operand;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: src/isre_cell.sv
// one storage cell of the sequence chain: holds the element at a fixed position
// depends on isre_pkg
`default_nettype none
module isre_cell #(
  parameter int IDX_W = 8,
  parameter int IDX   = 0
) (
  input  wire                     clk,
  input  wire isre_pkg::cell_ctrl_t ctrl,
  input  wire [63:0]              left_val,
  input  wire [63:0]              right_val,
  output logic [63:0]             value
);
  import isre_pkg::*;

  localparam int CMP_W = (IDX_W > 9) ? IDX_W + 1 : 10;

  logic [63:0]      value_r;
  logic [63:0]      value_nxt;
  logic [CMP_W-1:0] my_idx;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] last_x;

  assign my_idx = CMP_W'(IDX);
  assign pos_x  = CMP_W'(ctrl.pos);
  assign last_x = CMP_W'(ctrl.last);

  // per-cell update from the broadcast command
  always_comb begin
    value_nxt = value_r;
    unique case (ctrl.op)
      CELL_INS: begin
        if (my_idx > pos_x) value_nxt = left_val;
        else if (my_idx == pos_x) value_nxt = ctrl.operand;
      end
      CELL_REM: begin
        if (my_idx >= pos_x) value_nxt = right_val;
      end
      CELL_ADD: begin
        if (my_idx >= pos_x && my_idx <= last_x) value_nxt = value_r + ctrl.operand;
      end
      CELL_ROT: value_nxt = right_val;
      default:  value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule
`default_nettype wire

FILE: src/indexed_sequence_range_engine.sv
// insert, remove and range add do their work in the accept cycle; a result beat
// follows the next cycle. range query and sum lower bound rotate the cell ring
// once past the head cell in the scan state before their result beat.
// one item at a time; in_ready is high only while idle.
// synchronous active-low reset clears the count and control; element cells
// are not reset and hold meaning only below the count.
`default_nettype none
module indexed_sequence_range_engine #(
  parameter int CAPACITY = isre_pkg::CAPACITY_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire [2:0]         in_req_type,
  input  wire [8:0]         in_first_index,
  input  wire [7:0]         in_last_index,
  input  wire signed [63:0] in_operand,
  output logic              out_valid,
  input  wire               out_ready,
  output logic              out_status,
  output logic signed [63:0] out_span_sum,
  output logic signed [63:0] out_span_max,
  output logic signed [8:0] out_found_position,
  output logic [8:0]        out_element_count
);
  import isre_pkg::*;

  `include "assert_macros.svh"

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 9) ? CNT_W + 1 : 10;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [2:0]       req_r, req_nxt;
  logic [8:0]       first_r, first_nxt;
  logic [7:0]       last_r, last_nxt;
  logic [63:0]      opnd_r, opnd_nxt;
  logic [63:0]      sum_r, sum_nxt;
  logic [63:0]      max_r, max_nxt;
  logic             hit_r, hit_nxt;
  logic [8:0]       found_r, found_nxt;
  logic             status_r, status_nxt;

  cell_ctrl_t ctrl;
  logic [63:0] cell_val [CAPACITY];

  logic             accept;
  logic [CMP_W-1:0] first_x, last_x, count_x;
  logic             span_ok;
  logic [CMP_W-1:0] ins_pos;
  logic [63:0]      head;
  logic [CMP_W-1:0] step_x;
  logic             in_span;
  logic [63:0]      run;

  assign accept  = in_valid && in_ready;
  assign first_x = CMP_W'(in_first_index);
  assign last_x  = CMP_W'(in_last_index);
  assign count_x = CMP_W'(count_r);
  assign span_ok = (first_x <= last_x) && (last_x < count_x);
  assign ins_pos = (first_x > count_x) ? count_x : first_x;
  assign head    = cell_val[0];
  assign step_x  = CMP_W'(step_r);
  assign in_span = (step_x >= CMP_W'(first_r)) && (step_x <= CMP_W'(last_r));
  assign run     = sum_r + head;

  // chain of cells; the last cell wraps to the head for rotation
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [63:0] lv, rv;
    if (g == 0) begin : g_l0
      assign lv = 64'd0;
    end else begin : g_ln
      assign lv = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_rw
      assign rv = cell_val[0];
    end else begin : g_rn
      assign rv = cell_val[g+1];
    end
    isre_cell #(.IDX_W(IDX_W), .IDX(g)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_val  (lv),
      .right_val (rv),
      .value     (cell_val[g])
    );
  end

  // control sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    step_nxt   = step_r;
    req_nxt    = req_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    opnd_nxt   = opnd_r;
    sum_nxt    = sum_r;
    max_nxt    = max_r;
    hit_nxt    = hit_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    ctrl.op      = CELL_HOLD;
    ctrl.pos     = in_first_index;
    ctrl.last    = in_last_index;
    ctrl.operand = in_operand;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt    = in_req_type;
          first_nxt  = in_first_index;
          last_nxt   = in_last_index;
          opnd_nxt   = in_operand;
          sum_nxt    = 64'd0;
          max_nxt    = 64'd0;
          hit_nxt    = 1'b0;
          found_nxt  = 9'h1FF;
          status_nxt = 1'b1;
          step_nxt   = '0;
          state_nxt  = ST_OUT;
          unique case (in_req_type)
            REQ_INSERT: begin
              if (count_r != CNT_W'(CAPACITY)) begin
                ctrl.op    = CELL_INS;
                ctrl.pos   = ins_pos[8:0];
                count_nxt  = count_r + 1'b1;
                status_nxt = 1'b0;
              end
            end
            REQ_REMOVE: begin
              if (first_x < count_x) begin
                ctrl.op    = CELL_REM;
                count_nxt  = count_r - 1'b1;
                status_nxt = 1'b0;
              end
            end
            REQ_ADD: begin
              if (span_ok) begin
                ctrl.op    = CELL_ADD;
                status_nxt = 1'b0;
              end
            end
            REQ_QUERY, REQ_LBOUND: begin
              if (span_ok) begin
                status_nxt = 1'b0;
                state_nxt  = ST_SCAN;
              end
            end
            default: status_nxt = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        ctrl.op = CELL_ROT;
        if (in_span) begin
          if (req_r == REQ_QUERY) begin
            sum_nxt = run;
            if (step_x == CMP_W'(first_r) || $signed(head) > $signed(max_r))
              max_nxt = head;
          end else if (!hit_r) begin
            sum_nxt = run;
            if ($signed(run) >= $signed(opnd_r)) begin
              hit_nxt   = 1'b1;
              found_nxt = 9'(step_r);
            end
          end
        end
        if (step_r == IDX_W'(CAPACITY - 1)) begin
          state_nxt = ST_OUT;
          step_nxt  = '0;
          if (req_r != REQ_QUERY) begin
            sum_nxt = 64'd0;
            max_nxt = 64'd0;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
    end
    req_r    <= req_nxt;
    first_r  <= first_nxt;
    last_r   <= last_nxt;
    opnd_r   <= opnd_nxt;
    sum_r    <= sum_nxt;
    max_r    <= max_nxt;
    hit_r    <= hit_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

  // result beat
  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = (state_r == ST_OUT);
  assign out_status         = status_r;
  assign out_span_sum       = sum_r;
  assign out_span_max       = max_r;
  assign out_found_position = found_r;
  assign out_element_count  = 9'(count_r);

  `ISRE_ASSERT(a_count_cap, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `ISRE_ASSERT(a_ready_excl, !(in_ready && out_valid), "ready while result pending")
  `ISRE_ASSERT(a_step_idle, state_r == ST_SCAN || step_r == '0, "scan step outside scan")
  `ISRE_ASSERT_NEXT(a_count_hold, state_r != ST_IDLE, $stable(count_r), "count moved while busy")

endmodule
`default_nettype wire

FILE: tb/sv/tb_indexed_sequence_range_engine.sv
// testbench for indexed_sequence_range_engine: directed and random requests,
// checked beat by beat against a behavioral sequence predictor in a scoreboard
// depends on isre_pkg and the engine rtl
`default_nettype none
module tb_indexed_sequence_range_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import isre_pkg::*;

  localparam int CAP = 256;
  localparam logic [2:0] REQ_BAD = 3'd5;
  localparam logic [2:0] REQ_BAD_HI = 3'd7;

  typedef struct packed {
    logic        status;
    logic [63:0] span_sum;
    logic [63:0] span_max;
    logic [8:0]  found_pos;
    logic [8:0]  elem_count;
  } seq_result_t;

  // scoreboard: holds a copy of the sequence and a queue of expected results
  class seq_scoreboard;
    logic [63:0] seq_vals[CAP];
    int unsigned seq_len;
    seq_result_t pending[$];
    int errors;

    function new();
      seq_len = 0;
      errors = 0;
    endfunction

    // apply one accepted request to the predicted sequence
    function void note_request(logic [2:0] kind, logic [8:0] first, logic [7:0] last,
                               logic [63:0] opnd);
      seq_result_t r;
      logic span_ok;
      logic [63:0] run;
      int unsigned pos;
      r.status = 1'b1;
      r.span_sum = '0;
      r.span_max = '0;
      r.found_pos = '1;
      span_ok = (first <= {1'b0, last}) && (last < seq_len);
      case (kind)
        REQ_INSERT: begin
          if (seq_len < CAP) begin
            pos = (first > seq_len) ? seq_len : first;
            for (int i = seq_len; i > pos; i--) seq_vals[i] = seq_vals[i-1];
            seq_vals[pos] = opnd;
            seq_len++;
            r.status = 1'b0;
          end
        end
        REQ_REMOVE: begin
          if (first < seq_len) begin
            for (int i = first; i < seq_len - 1; i++) seq_vals[i] = seq_vals[i+1];
            seq_len--;
            r.status = 1'b0;
          end
        end
        REQ_ADD: begin
          if (span_ok) begin
            for (int i = first; i <= last; i++) seq_vals[i] = seq_vals[i] + opnd;
            r.status = 1'b0;
          end
        end
        REQ_QUERY: begin
          if (span_ok) begin
            r.span_max = seq_vals[first];
            for (int i = first; i <= last; i++) begin
              r.span_sum = r.span_sum + seq_vals[i];
              if ($signed(seq_vals[i]) > $signed(r.span_max)) r.span_max = seq_vals[i];
            end
            r.status = 1'b0;
          end
        end
        REQ_LBOUND: begin
          if (span_ok) begin
            run = '0;
            for (int i = first; i <= last; i++) begin
              run = run + seq_vals[i];
              if ($signed(run) >= $signed(opnd)) begin
                r.found_pos = i[8:0];
                break;
              end
            end
            r.status = 1'b0;
          end
        end
        default: ;
      endcase
      r.elem_count = seq_len[8:0];
      pending.push_back(r);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(seq_result_t got);
      seq_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
        errors++;
      end
      if (got.span_sum !== exp_r.span_sum) begin
        $display("%0t: span_sum exp %h got %h", $realtime, exp_r.span_sum, got.span_sum);
        errors++;
      end
      if (got.span_max !== exp_r.span_max) begin
        $display("%0t: span_max exp %h got %h", $realtime, exp_r.span_max, got.span_max);
        errors++;
      end
      if (got.found_pos !== exp_r.found_pos) begin
        $display("%0t: found_position exp %h got %h", $realtime, exp_r.found_pos,
                 got.found_pos);
        errors++;
      end
      if (got.elem_count !== exp_r.elem_count) begin
        $display("%0t: element_count exp %0d got %0d", $realtime, exp_r.elem_count,
                 got.elem_count);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] in_req_type;
  logic [8:0] in_first_index;
  logic [7:0] in_last_index;
  logic signed [63:0] in_operand;
  logic out_status;
  logic signed [63:0] out_span_sum, out_span_max;
  logic signed [8:0] out_found_position;
  logic [8:0] out_element_count;

  seq_scoreboard sb;
  int unsigned cycle_count;
  int unsigned gap_left;
  int unsigned burst_left;

  indexed_sequence_range_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_first_index(in_first_index),
    .in_last_index(in_last_index), .in_operand(in_operand),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_span_sum(out_span_sum),
    .out_span_max(out_span_max), .out_found_position(out_found_position),
    .out_element_count(out_element_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle limit: ~1100 items plus stalls, many times over
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 3_000_000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: sample at rising edge, stall pattern changes at falling edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_status, out_span_sum, out_span_max, out_found_position,
                       out_element_count});
  end

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (cycle_count % 4000 < 1000) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // send one request beat, with burst and gap idling
  task automatic send_req(logic [2:0] kind, logic [8:0] first, logic [7:0] last,
                          logic [63:0] opnd);
    @(negedge clk);
    if (burst_left == 0) begin
      gap_left = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      repeat (gap_left) @(negedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_first_index <= first;
    in_last_index <= last;
    in_operand <= opnd;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, first, last, opnd);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return {$urandom, $urandom};
      default: return 64'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  // random request mostly with valid spans over the current length
  task automatic send_random();
    logic [2:0] kind;
    int unsigned n, a, b;
    n = sb.seq_len;
    kind = 3'($urandom_range(0, 4));
    if ($urandom_range(0, 19) == 0) kind = 3'($urandom_range(0, 7));
    if (n < 20 && $urandom_range(0, 1) == 0) kind = REQ_INSERT;
    if (n > 200 && $urandom_range(0, 1) == 0) kind = REQ_REMOVE;
    if (n == 0 || $urandom_range(0, 9) == 0) begin
      a = $urandom_range(0, 511);
      b = $urandom_range(0, 255);
    end else begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(a, n - 1);
    end
    send_req(kind, a[8:0], b[7:0], rand_value());
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_INSERT;
    in_first_index = '0;
    in_last_index = '0;
    in_operand = '0;
    burst_left = 0;
    gap_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty cases, extremes, append, unknown codes
    send_req(REQ_REMOVE, 9'd0, 8'd0, '0);
    send_req(REQ_QUERY, 9'd0, 8'd0, '0);
    send_req(REQ_INSERT, 9'd256, 8'd255, 64'h7fff_ffff_ffff_ffff);
    send_req(REQ_INSERT, 9'd0, 8'd0, 64'h8000_0000_0000_0000);
    send_req(REQ_INSERT, 9'd1, 8'd0, 64'd5);
    send_req(REQ_QUERY, 9'd0, 8'd2, '0);
    send_req(REQ_QUERY, 9'd2, 8'd1, '0);
    send_req(REQ_ADD, 9'd0, 8'd2, 64'h7fff_ffff_ffff_ffff);
    send_req(REQ_QUERY, 9'd0, 8'd2, '0);
    send_req(REQ_LBOUND, 9'd0, 8'd2, 64'h8000_0000_0000_0000);
    send_req(REQ_LBOUND, 9'd1, 8'd2, 64'h7fff_ffff_ffff_ffff);
    send_req(REQ_LBOUND, 9'd0, 8'd3, '0);
    send_req(REQ_BAD, 9'd0, 8'd0, '1);
    send_req(REQ_BAD_HI, 9'd511, 8'd255, '1);
    send_req(REQ_REMOVE, 9'd3, 8'd0, '0);
    send_req(REQ_REMOVE, 9'd1, 8'd0, '0);
    // fill to capacity, then insert when full and full-span work
    while (sb.seq_len < CAP) send_req(REQ_INSERT, 9'($urandom_range(0, 300)), 8'd0,
                                      rand_value());
    send_req(REQ_INSERT, 9'd0, 8'd0, 64'd1);
    send_req(REQ_QUERY, 9'd0, 8'd255, '0);
    send_req(REQ_ADD, 9'd0, 8'd255, 64'd3);
    send_req(REQ_LBOUND, 9'd0, 8'd255, 64'd0);
    send_req(REQ_REMOVE, 9'd255, 8'd0, '0);

    // hold off until everything drains
    while (sb.pending.size() != 0) @(negedge clk);

    repeat (800) send_random();

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
